// File: hdl/hte_pkg.sv
// ----------------------------------------------------------------------------
// hte_pkg
// Shared types and constants for the handle table engine.
// ----------------------------------------------------------------------------
package hte_pkg;

  localparam int unsigned DEF_TABLE_SLOTS = 64;
  localparam int unsigned DEF_ID_BITS     = 32;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned INDEX_W  = 16;
  localparam int unsigned HID_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned NEW_ID_W = 32;
  localparam int unsigned NEW_IX_W = 6;

  // free-slot search width per cycle
  localparam int unsigned SCAN_W     = 32;
  localparam int unsigned SCAN_POS_W = 5;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [FUNC_W-1:0] FUNC_VALIDATE   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_ACQUIRE    = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_INVALIDATE = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_ACTIVATE   = 3'd4;

  // classified operation; OP_REJECT covers anything that fails up front
  typedef enum logic [2:0] {
    OP_VALIDATE,
    OP_ACQUIRE,
    OP_RELEASE,
    OP_INVALIDATE,
    OP_ACTIVATE,
    OP_REJECT
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_HANDLE_ERR = 2'd1,
    ST_NO_SPACE   = 2'd2
  } status_t;

  typedef struct packed {
    op_t                op;
    logic [INDEX_W-1:0] idx;
    logic [HID_W-1:0]   hid;
  } req_t;

endpackage

// File: hdl/hte_if.sv
// ----------------------------------------------------------------------------
// hte_if
// Channel interfaces: request, response and configuration write.
// ----------------------------------------------------------------------------
interface hte_req_if;
  import hte_pkg::*;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [INDEX_W-1:0]  handle_index;
  logic [HID_W-1:0]    handle_id;
  modport source (output valid, output func, output handle_index, output handle_id,
                  input ready);
  modport sink   (input valid, input func, input handle_index, input handle_id,
                  output ready);
endinterface

interface hte_rsp_if;
  import hte_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [NEW_ID_W-1:0] new_id;
  logic [NEW_IX_W-1:0] new_index;
  modport source (output valid, output status, output new_id, output new_index,
                  input ready);
  modport sink   (input valid, input status, input new_id, input new_index,
                  output ready);
endinterface

interface hte_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] starting_id;
  modport source (output valid, output starting_id, input ready);
  modport sink   (input valid, input starting_id, output ready);
endinterface

// File: hdl/hte_front.sv
// ----------------------------------------------------------------------------
// hte_front
// Accepts requests and classifies them before they enter the queue.
// ----------------------------------------------------------------------------
module hte_front
  import hte_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = DEF_TABLE_SLOTS
) (
  hte_req_if.sink     in_ch,
  output logic        push_valid,
  input  logic        push_ready,
  output req_t        push_data
);

  logic in_range;
  logic id_live;

  assign in_range = {1'b0, in_ch.handle_index} < (INDEX_W+1)'(TABLE_SLOTS);
  // ID zero is the free marker and never names a live slot
  assign id_live  = in_ch.handle_id != '0;

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;

  always_comb begin
    push_data.idx = in_ch.handle_index;
    push_data.hid = in_ch.handle_id;
    unique case (in_ch.func)
      FUNC_VALIDATE:   push_data.op = OP_VALIDATE;
      FUNC_ACQUIRE:    push_data.op = OP_ACQUIRE;
      FUNC_RELEASE:    push_data.op = OP_RELEASE;
      FUNC_INVALIDATE: push_data.op = OP_INVALIDATE;
      FUNC_ACTIVATE:   push_data.op = OP_ACTIVATE;
      default:         push_data.op = OP_REJECT;
    endcase
    if (push_data.op != OP_ACTIVATE && !(in_range && id_live)) begin
      push_data.op = OP_REJECT;
    end
  end

endmodule

// File: hdl/hte_queue.sv
// ----------------------------------------------------------------------------
// hte_queue
// Short FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
module hte_queue
  import hte_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  req_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output req_t pop_data
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  req_t             slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = count_r != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: hdl/hte_back.sv
// ----------------------------------------------------------------------------
// hte_back
// Executes queued requests against the slot table and drives responses.
// ----------------------------------------------------------------------------
module hte_back
  import hte_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = DEF_TABLE_SLOTS,
  parameter int unsigned ID_BITS     = DEF_ID_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  req_t        pop_data,
  hte_cfg_if.sink     cfg_ch,
  hte_rsp_if.source   out_ch
);

  localparam int unsigned IDX_W   = $clog2(TABLE_SLOTS);
  localparam int unsigned NCHUNK  = (TABLE_SLOTS + SCAN_W - 1) / SCAN_W;
  localparam int unsigned CIDX_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int unsigned SLOT_FW = CIDX_W + SCAN_POS_W;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN, S_ACT} state_t;

  state_t              state_r, state_nxt;
  req_t                req_r, req_nxt;
  logic [TABLE_SLOTS-1:0] used_r, used_nxt;
  logic [TABLE_SLOTS-1:0] lock_r, lock_nxt;
  logic [ID_BITS-1:0]  counter_r, counter_nxt;
  logic [CIDX_W-1:0]   chunk_r, chunk_nxt;
  logic                found_r, found_nxt;
  logic                found_lock_r, found_lock_nxt;
  logic [IDX_W-1:0]    slot_r, slot_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             status_r, status_nxt;
  logic [NEW_ID_W-1:0] new_id_r, new_id_nxt;
  logic [NEW_IX_W-1:0] new_index_r, new_index_nxt;

  // slot ID store; an entry whose used bit is clear is treated as free whatever it holds
  logic [ID_BITS-1:0]  id_mem [TABLE_SLOTS];
  logic [ID_BITS-1:0]  rd_data_r;
  logic                mem_wr;

  logic                out_free;
  logic [IDX_W-1:0]    req_idx;
  logic                handle_ok;
  logic                cur_lock;
  logic [NCHUNK*SCAN_W-1:0] free_pad, lock_pad;
  logic [SCAN_W-1:0]   free_chunk, lock_chunk;
  logic [SCAN_POS_W-1:0] hit_pos;
  logic                hit_any;
  logic [SLOT_FW-1:0]  hit_slot;
  logic [ID_BITS-1:0]  cnt_inc, issued_id;
  logic [ID_BITS+NEW_ID_W-1:0] issued_ext;
  logic [IDX_W+NEW_IX_W-1:0]   slot_ext;
  logic [ID_BITS+HID_W-1:0]    stored_ext, claim_ext;
  logic [ID_BITS+32-1:0]       cfg_ext;

  assign out_free        = !out_valid_r || out_ch.ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = status_r;
  assign out_ch.new_id   = new_id_r;
  assign out_ch.new_index = new_index_r;
  assign cfg_ch.ready    = 1'b1;
  assign pop_ready       = (state_r == S_IDLE);

  assign req_idx    = req_r.idx[IDX_W-1:0];
  assign stored_ext = {{HID_W{1'b0}}, rd_data_r};
  assign claim_ext  = {{ID_BITS{1'b0}}, req_r.hid};
  assign handle_ok  = used_r[req_idx] && (stored_ext == claim_ext);
  assign cur_lock   = lock_r[req_idx];

  always_comb begin
    free_pad = '0;
    lock_pad = '0;
    free_pad[TABLE_SLOTS-1:0] = ~used_r;
    lock_pad[TABLE_SLOTS-1:0] = lock_r;
  end

  assign free_chunk = free_pad[chunk_r*SCAN_W +: SCAN_W];
  assign lock_chunk = lock_pad[chunk_r*SCAN_W +: SCAN_W];
  assign hit_any    = |free_chunk;

  always_comb begin
    hit_pos = '0;
    for (int i = SCAN_W - 1; i >= 0; i--) begin
      if (free_chunk[i]) begin
        hit_pos = SCAN_POS_W'(i);
      end
    end
  end

  assign hit_slot = {chunk_r, hit_pos};

  // counter wraps and skips the free marker
  assign cnt_inc    = counter_r + 1'b1;
  assign issued_id  = (cnt_inc == '0) ? ID_BITS'(1) : cnt_inc;
  assign issued_ext = {{NEW_ID_W{1'b0}}, issued_id};
  assign slot_ext   = {{NEW_IX_W{1'b0}}, slot_r};
  assign cfg_ext    = {{ID_BITS{1'b0}}, cfg_ch.starting_id};

  assign mem_wr = (state_r == S_ACT) && out_free && found_r && !found_lock_r;

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    used_nxt       = used_r;
    lock_nxt       = lock_r;
    counter_nxt    = counter_r;
    chunk_nxt      = chunk_r;
    found_nxt      = found_r;
    found_lock_nxt = found_lock_r;
    slot_nxt       = slot_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    status_nxt     = status_r;
    new_id_nxt     = new_id_r;
    new_index_nxt  = new_index_r;

    unique case (state_r)
      S_IDLE: begin
        if (pop_valid) begin
          req_nxt   = pop_data;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (req_r.op == OP_ACTIVATE) begin
          chunk_nxt = '0;
          state_nxt = S_SCAN;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          new_id_nxt    = '0;
          new_index_nxt = '0;
          status_nxt    = ST_HANDLE_ERR;
          unique case (req_r.op)
            OP_VALIDATE: begin
              if (handle_ok) status_nxt = ST_OK;
            end
            OP_ACQUIRE: begin
              if (handle_ok && !cur_lock) begin
                lock_nxt[req_idx] = 1'b1;
                status_nxt        = ST_OK;
              end
            end
            OP_RELEASE: begin
              if (handle_ok) begin
                lock_nxt[req_idx] = 1'b0;
                status_nxt        = ST_OK;
              end
            end
            OP_INVALIDATE: begin
              if (handle_ok && !cur_lock) begin
                used_nxt[req_idx] = 1'b0;
                status_nxt        = ST_OK;
              end
            end
            default: status_nxt = ST_HANDLE_ERR;
          endcase
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (hit_any) begin
          found_nxt      = 1'b1;
          found_lock_nxt = lock_chunk[hit_pos];
          slot_nxt       = hit_slot[IDX_W-1:0];
          state_nxt      = S_ACT;
        end else if (chunk_r == CIDX_W'(NCHUNK - 1)) begin
          found_nxt      = 1'b0;
          found_lock_nxt = 1'b0;
          state_nxt      = S_ACT;
        end else begin
          chunk_nxt = chunk_r + 1'b1;
        end
      end
      S_ACT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          new_id_nxt    = '0;
          new_index_nxt = '0;
          if (!found_r) begin
            status_nxt = ST_NO_SPACE;
          end else if (found_lock_r) begin
            status_nxt = ST_HANDLE_ERR;
          end else begin
            status_nxt       = ST_OK;
            counter_nxt      = issued_id;
            used_nxt[slot_r] = 1'b1;
            new_id_nxt       = issued_ext[NEW_ID_W-1:0];
            new_index_nxt    = slot_ext[NEW_IX_W-1:0];
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_ch.valid) begin
      counter_nxt = cfg_ext[ID_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      used_r       <= '0;
      lock_r       <= '0;
      counter_r    <= '0;
      out_valid_r  <= 1'b0;
      chunk_r      <= '0;
      found_r      <= 1'b0;
      found_lock_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      used_r       <= used_nxt;
      lock_r       <= lock_nxt;
      counter_r    <= counter_nxt;
      out_valid_r  <= out_valid_nxt;
      chunk_r      <= chunk_nxt;
      found_r      <= found_nxt;
      found_lock_r <= found_lock_nxt;
    end
    req_r       <= req_nxt;
    slot_r      <= slot_nxt;
    status_r    <= status_nxt;
    new_id_r    <= new_id_nxt;
    new_index_r <= new_index_nxt;
  end

  // slot ID is read once, as the request is popped, and held while it waits
  always_ff @(posedge clk) begin
    if (mem_wr) begin
      id_mem[slot_r] <= issued_id;
    end
    if (pop_valid && pop_ready) begin
      rd_data_r <= id_mem[pop_data.idx[IDX_W-1:0]];
    end
  end

endmodule

// File: hdl/handle_table_engine.sv
// ----------------------------------------------------------------------------
// handle_table_engine
// Generational handle table: validate, acquire, release, invalidate, activate.
// ----------------------------------------------------------------------------
// Channels: in_ch carries requests (func, handle_index, handle_id), out_ch
// returns exactly one response per request (status, new_id, new_index) in
// request order, cfg_ch writes starting_id, which also reloads the ID counter.
// Write cfg_ch only while no request is outstanding.
// A front stage classifies requests (range, free-marker ID, unknown code)
// into a two-entry queue; the back end runs one request at a time.
// Validate, acquire, release and invalidate read the slot ID from the table
// memory as the request is popped, then check and update the slot.
// Activate reads, dispatches, searches the used bitmap 32 slots per cycle over
// up to ceil(TABLE_SLOTS/32) chunks, then writes the new ID.
// Reset clears all used and lock bits (every slot free; ID memory not cleared),
// the counter, the queue and the response valid bit; no clearing pass.
// A stalled out_ch holds the response; the queue keeps taking requests
// until full, then in_ch.ready falls.
// ----------------------------------------------------------------------------
module handle_table_engine
  import hte_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = DEF_TABLE_SLOTS,
  parameter int unsigned ID_BITS     = DEF_ID_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  hte_req_if.sink    in_ch,
  hte_rsp_if.source  out_ch,
  hte_cfg_if.sink    cfg_ch
);

  logic push_valid, push_ready;
  req_t push_data;
  logic pop_valid, pop_ready;
  req_t pop_data;

  hte_front #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  hte_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  hte_back #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .ID_BITS     (ID_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .cfg_ch    (cfg_ch),
    .out_ch    (out_ch)
  );

endmodule

// File: test/handle_table_engine_tb.sv
// ----------------------------------------------------------------------------
// handle_table_engine_tb
// Self-checking bench for the generational handle table engine.
// ----------------------------------------------------------------------------
// A shadow copy of the slot IDs, lock bits and ID counter predicts the
// response to each accepted request. Responses are checked in order, field by
// field. A short directed run covers the corner cases. Three random phases
// follow, each with its own starting ID and its own pattern of sender and
// receiver stalls. Fill and drain stretches push the table to full and back.
// ----------------------------------------------------------------------------
module handle_table_engine_tb;
  import hte_pkg::*;

  localparam int unsigned TABLE_SLOTS  = DEF_TABLE_SLOTS;
  localparam logic [HID_W-1:0] FREE_ID = '0;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_ITEMS  = 300;
  localparam int BLOCK_ITEMS  = 75;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [NEW_ID_W-1:0] new_id;
    logic [NEW_IX_W-1:0] new_index;
  } response_t;

  class handle_table_shadow;
    logic [HID_W-1:0] slot_ids [TABLE_SLOTS];
    bit               slot_locks [TABLE_SLOTS];
    logic [HID_W-1:0] id_counter;
    response_t        pending_responses [$];
    int mismatches, n_requests, n_issued, n_full, n_errors;

    function new();
      foreach (slot_ids[i]) begin
        slot_ids[i]   = FREE_ID;
        slot_locks[i] = 1'b0;
      end
      id_counter = '0;
    endfunction

    function void load_counter(logic [31:0] value);
      id_counter = value;
    endfunction

    function bit handle_live(logic [INDEX_W-1:0] idx, logic [HID_W-1:0] hid);
      if (idx >= TABLE_SLOTS || hid == FREE_ID) return 1'b0;
      return slot_ids[idx] == hid;
    endfunction

    // random live slot with its correct ID; zeros if the table is empty
    function bit pick_live(output logic [INDEX_W-1:0] idx, output logic [HID_W-1:0] hid);
      int start;
      int slot;
      idx   = '0;
      hid   = FREE_ID;
      start = $urandom_range(TABLE_SLOTS-1);
      for (int k = 0; k < TABLE_SLOTS; k++) begin
        slot = (start + k) % TABLE_SLOTS;
        if (slot_ids[slot] != FREE_ID) begin
          idx = INDEX_W'(slot);
          hid = slot_ids[slot];
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function response_t activate_slot();
      response_t        rsp;
      logic [HID_W-1:0] next_id;
      rsp.status    = ST_NO_SPACE;
      rsp.new_id    = '0;
      rsp.new_index = '0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        if (slot_ids[i] == FREE_ID) begin
          if (slot_locks[i]) begin
            rsp.status = ST_HANDLE_ERR;
            return rsp;
          end
          // counter wraps past the free marker
          next_id = id_counter + 1'b1;
          if (next_id == FREE_ID) next_id = HID_W'(1);
          id_counter    = next_id;
          slot_ids[i]   = next_id;
          rsp.status    = ST_OK;
          rsp.new_id    = next_id;
          rsp.new_index = NEW_IX_W'(i);
          return rsp;
        end
      end
      return rsp;
    endfunction

    function void note_request(logic [FUNC_W-1:0] func, logic [INDEX_W-1:0] idx,
                               logic [HID_W-1:0] hid);
      response_t rsp;
      bit        live;
      int        slot;
      rsp.status    = ST_HANDLE_ERR;
      rsp.new_id    = '0;
      rsp.new_index = '0;
      live = handle_live(idx, hid);
      slot = live ? int'(idx) : 0;
      case (func)
        FUNC_VALIDATE: if (live) rsp.status = ST_OK;
        FUNC_ACQUIRE: if (live && !slot_locks[slot]) begin
          slot_locks[slot] = 1'b1;
          rsp.status = ST_OK;
        end
        FUNC_RELEASE: if (live) begin
          slot_locks[slot] = 1'b0;
          rsp.status = ST_OK;
        end
        FUNC_INVALIDATE: if (live && !slot_locks[slot]) begin
          slot_ids[slot] = FREE_ID;
          rsp.status = ST_OK;
        end
        FUNC_ACTIVATE: begin
          rsp = activate_slot();
          if (rsp.status == ST_OK) n_issued++;
        end
        default: ;
      endcase
      n_requests++;
      if (rsp.status == ST_NO_SPACE) n_full++;
      if (rsp.status == ST_HANDLE_ERR) n_errors++;
      pending_responses.push_back(rsp);
    endfunction

    function void check_response(logic [STATUS_W-1:0] status, logic [NEW_ID_W-1:0] new_id,
                                 logic [NEW_IX_W-1:0] new_index);
      response_t exp;
      if (pending_responses.size() == 0) begin
        $error("response transaction with no request outstanding");
        mismatches++;
        return;
      end
      exp = pending_responses.pop_front();
      if (status !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, status);
        mismatches++;
      end
      if (new_id !== exp.new_id) begin
        $error("new_id: expected 0x%08h, actual 0x%08h", exp.new_id, new_id);
        mismatches++;
      end
      if (new_index !== exp.new_index) begin
        $error("new_index: expected %0d, actual %0d", exp.new_index, new_index);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;

  hte_req_if req_ch ();
  hte_rsp_if rsp_ch ();
  hte_cfg_if cfg_ch ();

  handle_table_shadow shadow = new();

  handle_table_engine DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (rsp_ch),
    .cfg_ch (cfg_ch)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && req_ch.valid && req_ch.ready)
      shadow.note_request(req_ch.func, req_ch.handle_index, req_ch.handle_id);
    if (rst_n && rsp_ch.valid && rsp_ch.ready)
      shadow.check_response(rsp_ch.status, rsp_ch.new_id, rsp_ch.new_index);
    if (rst_n && cfg_ch.valid && cfg_ch.ready)
      shadow.load_counter(cfg_ch.starting_id);
  end

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic issue_request(logic [FUNC_W-1:0] func, logic [INDEX_W-1:0] idx,
                               logic [HID_W-1:0] hid);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.func         <= func;
    req_ch.handle_index <= idx;
    req_ch.handle_id    <= hid;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // drops valid and lets the monitor note the last accepted request before checking
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (shadow.pending_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_starting_id(logic [31:0] value);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.starting_id <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // mostly activates or well-formed handles on live slots; the rest is noise
  task automatic random_request(bit fill);
    logic [FUNC_W-1:0]  func;
    logic [INDEX_W-1:0] idx;
    logic [HID_W-1:0]   hid;
    int                 roll;
    int                 pick;
    roll = $urandom_range(99);
    func = FUNC_ACTIVATE;
    idx  = INDEX_W'($urandom);
    hid  = $urandom;
    if (roll < 12) begin
      func = FUNC_W'($urandom_range(7));
      case ($urandom_range(2))
        0: if (shadow.pick_live(idx, hid)) hid = hid ^ (32'd1 << $urandom_range(31));
        1: begin
          idx = INDEX_W'($urandom_range(TABLE_SLOTS-1));
          hid = ($urandom_range(3) == 0) ? FREE_ID : HID_W'($urandom);
        end
        default: ;
      endcase
    end else if (roll < 12 + (fill ? 60 : 6)) begin
      func = FUNC_ACTIVATE;
    end else if (shadow.pick_live(idx, hid)) begin
      pick = $urandom_range(99);
      if (fill)
        func = (pick < 25) ? FUNC_VALIDATE : (pick < 50) ? FUNC_ACQUIRE :
               (pick < 75) ? FUNC_RELEASE : FUNC_INVALIDATE;
      else
        func = (pick < 15) ? FUNC_VALIDATE : (pick < 30) ? FUNC_ACQUIRE :
               (pick < 60) ? FUNC_RELEASE : FUNC_INVALIDATE;
    end
    issue_request(func, idx, hid);
  endtask

  task automatic run_phase(int s_pct, int r_pct, logic [31:0] start_id);
    wait_idle();
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    write_starting_id(start_id);
    for (int i = 0; i < PHASE_ITEMS; i++)
      random_request(((i / BLOCK_ITEMS) % 2) == 0);
  endtask

  initial begin
    rst_n               = 1'b0;
    send_idle_pct       = 22;
    recv_idle_pct       = 49;
    req_ch.valid        = 1'b0;
    req_ch.func         = FUNC_VALIDATE;
    req_ch.handle_index = '0;
    req_ch.handle_id    = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.starting_id  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // counter starts from its reset value: IDs 1 and 2 into slots 0 and 1
    issue_request(FUNC_ACTIVATE, '0, '0);
    issue_request(FUNC_ACTIVATE, 16'hFFFF, 32'hFFFF_FFFF);
    issue_request(FUNC_VALIDATE, 16'd0, 32'd1);
    issue_request(FUNC_VALIDATE, 16'd0, FREE_ID);
    issue_request(FUNC_VALIDATE, 16'hFFFF, 32'd1);
    issue_request(FUNC_VALIDATE, 16'(TABLE_SLOTS), 32'd1);
    issue_request(FUNC_ACQUIRE, 16'd0, 32'd1);
    issue_request(FUNC_ACQUIRE, 16'd0, 32'd1);
    issue_request(FUNC_INVALIDATE, 16'd0, 32'd1);
    issue_request(FUNC_RELEASE, 16'd0, 32'd1);
    issue_request(FUNC_RELEASE, 16'd0, 32'd1);
    issue_request(FUNC_INVALIDATE, 16'd0, 32'd1);
    issue_request(FUNC_VALIDATE, 16'd0, 32'd1);
    issue_request(FUNC_VALIDATE, 16'd1, 32'hFFFF_FFFF);
    for (int f = int'(FUNC_ACTIVATE) + 1; f < (1 << FUNC_W); f++)
      issue_request(FUNC_W'(f), 16'd1, 32'd2);

    // counter wrap: top ID issued, then the marker is skipped
    wait_idle();
    write_starting_id(32'hFFFF_FFFE);
    issue_request(FUNC_ACTIVATE, '0, '0);
    issue_request(FUNC_ACTIVATE, '0, '0);
    issue_request(FUNC_VALIDATE, 16'd0, 32'hFFFF_FFFF);
    issue_request(FUNC_RELEASE, 16'd2, 32'd1);
    issue_request(FUNC_INVALIDATE, 16'd1, 32'd2);

    run_phase(22, 49, $urandom);
    run_phase(49, 22, 32'hFFFF_FFFF);
    run_phase(0, 0, 32'h0000_0000);

    wait_idle();
    $display("Ran %0d requests through four starting IDs and three stall patterns.",
             shadow.n_requests);
    $display("%0d IDs issued, %0d table-full and %0d handle-error responses.",
             shadow.n_issued, shadow.n_full, shadow.n_errors);
    if (shadow.mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// File: files.f
hdl/hte_pkg.sv
hdl/hte_if.sv
hdl/hte_front.sv
hdl/hte_queue.sv
hdl/hte_back.sv
hdl/handle_table_engine.sv
test/handle_table_engine_tb.sv
